>>> rtl/ucbp_pkg.sv
// Shared types and constants for the universal code bit packer.
// No dependencies.
package ucbp_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned RomDepth = 93;

  typedef enum logic [2:0] {
    CMD_UNARY  = 3'd0,
    CMD_BINARY = 3'd1,
    CMD_GAMMA  = 3'd2,
    CMD_DELTA  = 3'd3,
    CMD_FIB    = 3'd4
  } cmd_t;

  // One queued job for the back end.
  typedef struct packed {
    logic        err;
    logic        flush;
    logic [2:0]  cmd;
    logic [63:0] value;
    logic [6:0]  width;
  } job_t;

  // Fibonacci number with index i (1, 1, 2, 3, ...), computed as a constant function
  // only at elaboration-time call sites with constant arguments or as a ROM.
  function automatic logic [63:0] fib_rom(input logic [6:0] i);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] t;
    a = 64'd1;
    b = 64'd1;
    for (int k = 0; k < 93; k++) begin
      if (k < int'(i)) begin
        t = a + b;
        a = b;
        b = t;
      end
    end
    return a;
  endfunction

endpackage

>>> rtl/ucbp_front.sv
// Front end: checks each item and queues it for the back end.
// Depends on ucbp_pkg.
module ucbp_front #(
  parameter int unsigned MAX_UNARY = 255,
  parameter int unsigned FIB_TERMS = 93
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_cmd,
  input  logic [63:0]       in_value,
  input  logic [6:0]        in_width,
  input  logic              in_flush,
  output logic              q_valid,
  input  logic              q_ready,
  output ucbp_pkg::job_t    q_job
);
  localparam int unsigned QDepth = 2;
  localparam logic [63:0] FibLimit = ucbp_pkg::fib_rom(7'(FIB_TERMS % 93));

  ucbp_pkg::job_t slots [QDepth];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       bad;
  ucbp_pkg::job_t job_in;

  always_comb begin
    unique case (in_cmd)
      ucbp_pkg::CMD_UNARY:  bad = in_value > 64'(MAX_UNARY);
      ucbp_pkg::CMD_BINARY: bad = 1'b0;
      ucbp_pkg::CMD_GAMMA,
      ucbp_pkg::CMD_DELTA:  bad = in_value == 64'd0;
      ucbp_pkg::CMD_FIB:
        bad = (in_value == 64'd0) || ((FIB_TERMS < 93) && (in_value >= FibLimit));
      default:              bad = 1'b1;
    endcase
    job_in.err   = bad;
    job_in.flush = in_flush;
    job_in.cmd   = in_cmd;
    job_in.value = in_value;
    job_in.width = (in_width > 7'd64) ? 7'd64 : in_width;
  end

  assign in_ready = cnt != 2'(QDepth);
  assign q_valid  = cnt != 2'd0;
  assign q_job    = slots[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slots[wp] <= job_in;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

>>> rtl/ucbp_back.sv
// Back end: turns one job into code chunks and packs them into 64-bit words.
// Depends on ucbp_pkg.
module ucbp_back #(
  parameter int unsigned FIB_TERMS = 93
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  ucbp_pkg::job_t q_job,
  output logic           o_valid,
  input  logic           o_ready,
  output logic [63:0]    o_word,
  output logic [6:0]     o_bits,
  output logic           o_last,
  output logic           o_err
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LEN   = 7'b0000010,
    S_CHUNK = 7'b0000100,
    S_FSCAN = 7'b0001000,
    S_FSEL  = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_ERR   = 7'b1000000
  } state_t;

  state_t      state;
  ucbp_pkg::job_t job;
  logic [63:0] pword;
  logic [5:0]  pbits;
  // chunk list: up to 4 segments of (data, count)
  logic [63:0] seg_v [4];
  logic [6:0]  seg_n [4];
  logic [12:0] zeros;        // leading zeros still to emit (unary, gamma, delta)
  logic [12:0] rem;          // code bits not yet appended
  logic [1:0]  seg_i;
  logic [2:0]  seg_cnt;
  logic [6:0]  fidx;
  logic [63:0] frem;
  logic [92:0] fused;
  logic [6:0]  ftop;
  logic [6:0]  blen_v, blen_l;
  logic [63:0] fib_cur;
  logic [63:0] fib_tab [128];

  // segments for the non-Fibonacci codes
  logic [63:0] lseg_v [4];
  logic [6:0]  lseg_n [4];
  logic [12:0] lzeros;
  logic [2:0]  lcnt;
  logic [12:0] lrem;
  // segments for the Fibonacci code body
  logic [63:0] fseg_v [2];
  logic [6:0]  fseg_n [2];

  // current chunk to append
  logic [63:0] ch_v;
  logic [6:0]  ch_n;
  logic [63:0] mask;
  logic [63:0] vm;
  logic [6:0]  space;
  logic [6:0]  rest;
  logic        fill;
  logic [63:0] merged;
  logic [63:0] carry;
  logic [12:0] left;
  logic        wlast;
  logic        out_free;
  logic        step;
  logic        emit;

  for (genvar g = 0; g < 128; g++) begin : g_fib
    localparam logic [63:0] FibVal = ucbp_pkg::fib_rom(7'(g));
    assign fib_tab[g] = FibVal;
  end

  assign out_free = !o_valid || o_ready;
  assign fib_cur  = fib_tab[fidx];

  always_comb begin
    blen_v = 7'd0;
    for (int k = 0; k < 64; k++) if (job.value[k]) blen_v = 7'(k + 1);
    blen_l = 7'd0;
    for (int k = 0; k < 7; k++) if (blen_v[k]) blen_l = 7'(k + 1);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lseg_v[k] = 64'd0;
      lseg_n[k] = 7'd0;
    end
    lzeros = 13'd0;
    lcnt   = 3'd1;
    unique case (job.cmd)
      ucbp_pkg::CMD_UNARY: begin
        lzeros    = job.value[12:0];
        lseg_v[0] = 64'd1;
        lseg_n[0] = 7'd1;
      end
      ucbp_pkg::CMD_BINARY: begin
        lseg_v[0] = job.value;
        lseg_n[0] = job.width;
      end
      ucbp_pkg::CMD_GAMMA: begin
        lzeros    = 13'(blen_v - 7'd1);
        lseg_v[0] = 64'd1;
        lseg_n[0] = 7'd1;
        lseg_v[1] = job.value;
        lseg_n[1] = blen_v - 7'd1;
        lcnt      = 3'd2;
      end
      default: begin
        lzeros    = 13'(blen_l - 7'd1);
        lseg_v[0] = 64'd1;
        lseg_n[0] = 7'd1;
        lseg_v[1] = 64'(blen_v);
        lseg_n[1] = blen_l - 7'd1;
        lseg_v[2] = job.value;
        lseg_n[2] = blen_v - 7'd1;
        lcnt      = 3'd3;
      end
    endcase
    lrem = lzeros + 13'(lseg_n[0]) + 13'(lseg_n[1]) + 13'(lseg_n[2]);
  end

  // bits used[1..top-1], low term first; segment 0 holds terms 1..64, segment 1 the rest
  always_comb begin
    fseg_v[0] = 64'd0;
    fseg_v[1] = 64'd0;
    if (ftop > 7'd65) begin
      fseg_n[0] = 7'd64;
      fseg_n[1] = ftop - 7'd65;
      for (int k = 1; k < 65; k++) fseg_v[0][64 - k] = fused[k];
      for (int k = 65; k < 93; k++)
        if (k < int'(ftop)) fseg_v[1][int'(ftop) - 1 - k] = fused[k];
    end else begin
      fseg_n[0] = ftop - 7'd1;
      fseg_n[1] = 7'd0;
      for (int k = 1; k < 65; k++)
        if (k < int'(ftop)) fseg_v[0][int'(ftop) - 1 - k] = fused[k];
    end
  end

  always_comb begin
    if (zeros != 13'd0) begin
      ch_v = 64'd0;
      ch_n = (zeros >= 13'd64) ? 7'd64 : zeros[6:0];
    end else begin
      ch_v = seg_v[seg_i];
      ch_n = seg_n[seg_i];
    end
    mask  = (ch_n == 7'd64) ? '1 : ((64'd1 << ch_n[5:0]) - 64'd1);
    vm    = ch_v & mask;
    space = 7'd64 - {1'b0, pbits};
    fill  = ch_n >= space;
    rest  = ch_n - space;
    if (!fill) begin
      merged = pword | (vm << (space - ch_n));
      carry  = 64'd0;
    end else begin
      merged = pword | (vm >> rest);
      carry  = (rest == 7'd0) ? 64'd0 : (vm << (7'd64 - rest));
    end
    // bits of this item left over once the current word is full
    left  = 13'(pbits) + rem - 13'd64;
    wlast = (left < 13'd64) && !(job.flush && left != 13'd0);
  end

  // a chunk step stalls only when it would write an output word
  assign step = (state == S_CHUNK) && (!fill || out_free);

  assign emit = ((state == S_ERR) && out_free) || (step && fill) ||
                ((state == S_FLUSH) && job.flush && (pbits != 6'd0) && out_free);

  assign q_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      pword   <= 64'd0;
      pbits   <= 6'd0;
    end else begin
      o_valid <= emit || (o_valid && !o_ready);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            job   <= q_job;
            seg_i <= 2'd0;
            zeros <= 13'd0;
            state <= q_job.err ? S_ERR :
                     (q_job.cmd == ucbp_pkg::CMD_FIB) ? S_FSCAN : S_LEN;
            fidx  <= 7'd0;
            frem  <= q_job.value;
            fused <= '0;
          end
        end
        S_ERR: begin
          if (out_free) begin
            o_word  <= 64'd0;
            o_bits  <= 7'd0;
            o_last  <= 1'b1;
            o_err   <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_LEN: begin
          for (int k = 0; k < 4; k++) begin
            seg_v[k] <= lseg_v[k];
            seg_n[k] <= lseg_n[k];
          end
          zeros   <= lzeros;
          seg_cnt <= lcnt;
          rem     <= lrem;
          state   <= S_CHUNK;
        end
        S_FSCAN: begin
          // find the count of table terms not above the value
          if (fidx < 7'(FIB_TERMS) && fib_cur <= job.value) fidx <= fidx + 7'd1;
          else begin
            ftop  <= fidx;
            fidx  <= fidx - 7'd1;
            state <= S_FSEL;
          end
        end
        S_FSEL: begin
          if (fib_cur <= frem) begin
            fused[fidx] <= 1'b1;
            frem        <= frem - fib_cur;
          end
          if (fidx == 7'd0) begin
            // fused[0] never matters; closing one is segment 2
            seg_v[0] <= fseg_v[0];
            seg_n[0] <= fseg_n[0];
            seg_v[1] <= fseg_v[1];
            seg_n[1] <= fseg_n[1];
            seg_v[2] <= 64'd1;
            seg_n[2] <= 7'd1;
            seg_v[3] <= 64'd0;
            seg_n[3] <= 7'd0;
            seg_cnt  <= 3'd3;
            rem      <= 13'(ftop);
            state    <= S_CHUNK;
          end else fidx <= fidx - 7'd1;
        end
        S_CHUNK: begin
          if (step) begin
            if (fill) begin
              o_word  <= merged;
              o_bits  <= 7'd64;
              o_last  <= wlast;
              o_err   <= 1'b0;
              pword   <= carry;
              pbits   <= rest[5:0];
            end else begin
              pword <= merged;
              pbits <= pbits + ch_n[5:0];
            end
            rem <= rem - 13'(ch_n);
            if (zeros != 13'd0) zeros <= zeros - 13'(ch_n);
            else if (3'(seg_i) + 3'd1 >= seg_cnt) state <= S_FLUSH;
            else seg_i <= seg_i + 2'd1;
          end
        end
        S_FLUSH: begin
          if (job.flush && pbits != 6'd0) begin
            if (out_free) begin
              o_word  <= pword;
              o_bits  <= {1'b0, pbits};
              o_last  <= 1'b1;
              o_err   <= 1'b0;
              pword   <= 64'd0;
              pbits   <= 6'd0;
              state   <= S_IDLE;
            end
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/universal_code_bit_packer_top.sv
// Top level of the universal code bit packer: front checker, job queue, back packer.
// Depends on ucbp_pkg, ucbp_front, ucbp_back.
// Path: the front end queues each item; the back end takes it when idle, sends a rejected item
// straight to an error result, and otherwise sizes the code (for Fibonacci: table scan, then
// term selection) before packing its chunks. The back end finishes one item before taking the next.
// Reset: synchronous, clears the partial word, the queue and the output register.
module universal_code_bit_packer_top #(
  parameter int unsigned MAX_UNARY = 255,
  parameter int unsigned FIB_TERMS = 93
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // cmd[2:0], value[66:3], width[73:67], zero pad
  input  logic        s_axis_tlast,  // end_of_batch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // word[63:0], word_bits[70:64], zero pad
  output logic        m_axis_tlast,  // last
  output logic        m_axis_tuser   // error
);
  logic           q_valid, q_ready;
  ucbp_pkg::job_t q_job;
  logic [63:0]    word;
  logic [6:0]     bits;

  ucbp_front #(.MAX_UNARY(MAX_UNARY), .FIB_TERMS(FIB_TERMS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(s_axis_tdata[2:0]), .in_value(s_axis_tdata[66:3]),
    .in_width(s_axis_tdata[73:67]), .in_flush(s_axis_tlast),
    .q_valid, .q_ready, .q_job
  );

  ucbp_back #(.FIB_TERMS(FIB_TERMS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job,
    .o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
    .o_word(word), .o_bits(bits), .o_last(m_axis_tlast), .o_err(m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, bits, word};
endmodule

>>> rtl/ucbp_checker.sv
// Port-level checks for the universal code bit packer, bound to the top level.
// Depends on nothing but the top level's ports.
module ucbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 72'd0)
    else $error("error result malformed");
  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[70:64] <= 7'd64)
    else $error("word_bits out of range");
  a_partial_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && m_axis_tdata[70:64] != 7'd64 |-> m_axis_tlast)
    else $error("partial word not last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast, m_axis_tuser}))
    else $error("output dropped while stalled");
endmodule

bind universal_code_bit_packer_top ucbp_checker u_chk (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
);
